/* src/icov_pkg.sv */
// ----------------------------------------------------------------------------
// icov_pkg: shared types and constants for the interval coverage tracker
// Payload structs, status codes and parameter defaults used by the tracker
// and its port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package icov_pkg;

  // Parameter defaults
  localparam int MAX_INTERVALS_DEF = 64;
  localparam int CELL_WIDTH_DEF    = 32;

  // total_cells after reset
  localparam logic [31:0] TOTAL_CELLS_RST = 32'd1024;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_BAD  = 2'd2;

  // Input transfer: one inclusive, one-based cell range
  typedef struct packed {
    logic [31:0] first_cell;
    logic [31:0] last_cell;
  } icov_in_t;

  // Result transfer
  typedef struct packed {
    logic [31:0] uncovered_cells;
    status_t     status;
  } icov_out_t;

endpackage

`default_nettype wire

/* src/interval_coverage_tracker.sv */
// ----------------------------------------------------------------------------
// interval_coverage_tracker: covered-cell tracking by interval merging
// Keeps a table of disjoint half-open intervals in a small memory, merges each
// new range with every entry it overlaps or touches, and returns the number of
// cells still uncovered together with a status code.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | input     | in_valid/in_stall  | in_data  (first_cell, last_cell)
//  out     | output    | out_valid/out_stall| out_data (uncovered_cells, status)
//  cfg     | input     | cfg_we             | cfg_wdata (total_cells)
//
//  A range is checked against every entry of the interval memory through its
//  single read port, one entry a cycle, and its result is posted from S_DONE;
//  no new range is taken until that result is posted. A malformed range skips
//  the scan and goes straight to S_DONE.
//  rst_n is synchronous and active low; it empties the table and reloads the
//  count with 1024. A result held by out_stall waits in the output register
//  while the next range is already taken and scanned; the scan then halts
//  before its result until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_coverage_tracker
  import icov_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
  parameter int CELL_WIDTH    = CELL_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  // range input
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire icov_in_t  in_data,
  // result output
  output logic           out_valid,
  input  wire logic      out_stall,
  output icov_out_t      out_data,
  // total_cells register
  input  wire logic      cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_INTERVALS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // Control and working registers
  logic [1:0]            state_r,    state_nxt;
  logic [CELL_WIDTH-1:0] total_r,    total_nxt;
  logic [CELL_WIDTH-1:0] uncov_r,    uncov_nxt;
  logic [CELL_WIDTH-1:0] lo_r,       lo_nxt;
  logic [CELL_WIDTH-1:0] hi_r,       hi_nxt;
  logic [CELL_WIDTH-1:0] cnt_r,      cnt_nxt;
  logic                  bad_r,      bad_nxt;
  logic [MAX_INTERVALS-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]      rd_ptr_r,   rd_ptr_nxt;
  logic                  rd_busy_r,  rd_busy_nxt;
  logic                  chk_vld_r,  chk_vld_nxt;
  logic [IDX_W-1:0]      chk_idx_r,  chk_idx_nxt;
  logic [IDX_W-1:0]      slot_r,     slot_nxt;
  logic                  slot_fnd_r, slot_fnd_nxt;
  logic                  out_valid_r, out_valid_nxt;
  icov_out_t             out_data_r, out_data_nxt;

  // Interval memory and its registered read data
  logic [CELL_WIDTH-1:0] mem_start [MAX_INTERVALS];
  logic [CELL_WIDTH-1:0] mem_end   [MAX_INTERVALS];
  logic [CELL_WIDTH-1:0] rd_start_r;
  logic [CELL_WIDTH-1:0] rd_end_r;
  logic                  rd_en;
  logic                  mem_we;

  // Combinational helpers
  logic [CELL_WIDTH-1:0] first_w;
  logic [CELL_WIDTH-1:0] last_w;
  logic                  bad_w;
  logic                  entry_vld;
  logic                  touch_w;
  logic                  out_free;

  assign first_w   = CELL_WIDTH'(in_data.first_cell);
  assign last_w    = CELL_WIDTH'(in_data.last_cell);
  assign bad_w     = (first_w == '0) || (last_w < first_w) || (last_w > total_r);
  assign entry_vld = valid_r[chk_idx_r];
  assign touch_w   = entry_vld && (rd_start_r <= hi_r) && (rd_end_r >= lo_r);
  assign out_free  = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer and shared compare/accumulate step
  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    uncov_nxt     = uncov_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cnt_nxt       = cnt_r;
    bad_nxt       = bad_r;
    valid_nxt     = valid_r;
    rd_ptr_nxt    = rd_ptr_r;
    rd_busy_nxt   = rd_busy_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    slot_nxt      = slot_r;
    slot_fnd_nxt  = slot_fnd_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    mem_we        = 1'b0;

    // drop the result once the far side takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        // take a range and turn it into the half-open span
        if (in_valid) begin
          lo_nxt       = first_w - CELL_WIDTH'(1);
          hi_nxt       = last_w;
          cnt_nxt      = uncov_r;
          bad_nxt      = bad_w;
          rd_ptr_nxt   = '0;
          rd_busy_nxt  = !bad_w;
          slot_fnd_nxt = 1'b0;
          state_nxt    = bad_w ? S_DONE : S_SCAN;
        end
      end

      S_SCAN: begin
        // issue the next memory read
        if (rd_busy_r) begin
          rd_en       = 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = rd_ptr_r;
          rd_ptr_nxt  = rd_ptr_r + IDX_W'(1);
          rd_busy_nxt = (rd_ptr_r != LAST_IDX);
        end
        // check the entry read last cycle against the growing span
        if (chk_vld_r) begin
          if (touch_w) begin
            cnt_nxt              = cnt_r + (rd_end_r - rd_start_r);
            lo_nxt               = (rd_start_r < lo_r) ? rd_start_r : lo_r;
            hi_nxt               = (rd_end_r > hi_r) ? rd_end_r : hi_r;
            valid_nxt[chk_idx_r] = 1'b0;
          end
          // first free or absorbed slot takes the merged interval
          if ((touch_w || !entry_vld) && !slot_fnd_r) begin
            slot_nxt     = chk_idx_r;
            slot_fnd_nxt = 1'b1;
          end
          if (chk_idx_r == LAST_IDX) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        // hold until the output register is free, then post the result
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (bad_r) begin
            out_data_nxt.uncovered_cells = 32'(uncov_r);
            out_data_nxt.status          = ST_BAD;
          end else if (!slot_fnd_r) begin
            out_data_nxt.uncovered_cells = 32'(uncov_r);
            out_data_nxt.status          = ST_FULL;
          end else begin
            mem_we                       = 1'b1;
            valid_nxt[slot_r]            = 1'b1;
            uncov_nxt                    = cnt_r - (hi_r - lo_r);
            out_data_nxt.uncovered_cells = 32'(cnt_r - (hi_r - lo_r));
            out_data_nxt.status          = ST_OK;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // register write: clear coverage and reload the count
    if (cfg_we) begin
      total_nxt = CELL_WIDTH'(cfg_wdata);
      uncov_nxt = CELL_WIDTH'(cfg_wdata);
      valid_nxt = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= CELL_WIDTH'(TOTAL_CELLS_RST);
      uncov_r     <= CELL_WIDTH'(TOTAL_CELLS_RST);
      valid_r     <= '0;
      rd_busy_r   <= 1'b0;
      chk_vld_r   <= 1'b0;
      slot_fnd_r  <= 1'b0;
      out_valid_r <= 1'b0;
      bad_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      uncov_r     <= uncov_nxt;
      valid_r     <= valid_nxt;
      rd_busy_r   <= rd_busy_nxt;
      chk_vld_r   <= chk_vld_nxt;
      slot_fnd_r  <= slot_fnd_nxt;
      out_valid_r <= out_valid_nxt;
      bad_r       <= bad_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    cnt_r      <= cnt_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    chk_idx_r  <= chk_idx_nxt;
    slot_r     <= slot_nxt;
    out_data_r <= out_data_nxt;
  end

  // Interval memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_start[slot_r] <= lo_r;
      mem_end[slot_r]   <= hi_r;
    end
    if (rd_en) begin
      rd_start_r <= mem_start[rd_ptr_r];
      rd_end_r   <= mem_end[rd_ptr_r];
    end
  end

endmodule

`default_nettype wire

/* src/icov_checker.sv */
// ----------------------------------------------------------------------------
// icov_port_checks: port checks for the interval coverage tracker
// Watches the tracker's ports for transfer ordering and payload holding, and
// is bound onto every instance of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module icov_port_checks
  import icov_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire icov_in_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire icov_out_t out_data
);

  logic [1:0] pend_r;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // Count ranges taken whose result has not yet been transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else if (in_xfer && !out_xfer) begin
      pend_r <= pend_r + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pend_r <= pend_r - 2'd1;
    end
  end

  // A stalled range holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("range changed or dropped while stalled");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // No result without a range behind it
  a_out_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result presented with no range outstanding");

  // At most one range in work besides a waiting result
  a_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 2'd2 |-> in_stall)
    else $error("range taken while two are outstanding");

  // Status carries one of its three codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_FULL ||
                   out_data.status == ST_BAD))
    else $error("result status out of range");

endmodule

bind interval_coverage_tracker icov_port_checks u_icov_port_checks (.*);

`default_nettype wire

/* tb/sv/icov_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// icov_checker: result predictor and scoreboard for the coverage tracker
// Watches the range, result and register ports, keeps its own copy of the
// interval table and uncovered count, and compares every result transfer
// field by field against the oldest predicted report.
// ----------------------------------------------------------------------------

module icov_checker
  import icov_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  icov_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  icov_out_t   out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  localparam int TABLE_DEPTH = MAX_INTERVALS_DEF;

  // Shadow of the tracker state; spans are half-open, held wide to avoid wrap
  logic [31:0] line_cells;
  logic [63:0] span_lo [TABLE_DEPTH];
  logic [63:0] span_hi [TABLE_DEPTH];
  bit          span_used [TABLE_DEPTH];
  logic [63:0] cells_left;

  icov_out_t   coverage_reports[$];
  int          errors = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Empty the table and reload the count from the line length
  function automatic void wipe_coverage();
    int i;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      span_used[i] = 1'b0;
      span_lo[i]   = '0;
      span_hi[i]   = '0;
    end
    cells_left = {32'd0, line_cells};
  endfunction

  // Apply one range to the shadow table and return the report it yields
  function automatic icov_out_t cover_range(input icov_in_t r);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] cnt;
    int          slot;
    bit          touches;
    int          i;
    icov_out_t   rep;
    slot    = -1;
    touches = 1'b0;
    rep.uncovered_cells = cells_left[31:0];
    // Malformed ranges leave everything alone
    if (r.first_cell == 32'd0 || r.last_cell < r.first_cell ||
        r.last_cell > line_cells) begin
      rep.status = ST_BAD;
      return rep;
    end
    lo = {32'd0, r.first_cell} - 64'd1;
    hi = {32'd0, r.last_cell};
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (span_used[i]) begin
        if (span_lo[i] <= hi && span_hi[i] >= lo) touches = 1'b1;
      end else if (slot < 0) begin
        slot = i;
      end
    end
    // No room and nothing to merge with: drop the range
    if (!touches && slot < 0) begin
      rep.status = ST_FULL;
      return rep;
    end
    // Absorb every touching span, giving its length back to the count
    cnt = cells_left;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (span_used[i] && span_lo[i] <= hi && span_hi[i] >= lo) begin
        cnt = cnt + (span_hi[i] - span_lo[i]);
        if (span_lo[i] < lo) lo = span_lo[i];
        if (span_hi[i] > hi) hi = span_hi[i];
        span_used[i] = 1'b0;
        if (slot < 0 || i < slot) slot = i;
      end
    end
    if (slot < 0) slot = 0;
    span_lo[slot]   = lo;
    span_hi[slot]   = hi;
    span_used[slot] = 1'b1;
    cnt        = cnt - (hi - lo);
    cells_left = {32'd0, cnt[31:0]};
    rep.uncovered_cells = cells_left[31:0];
    rep.status          = ST_OK;
    return rep;
  endfunction

  always @(posedge clk) begin
    icov_out_t want;
    if (!rst_n) begin
      line_cells = TOTAL_CELLS_RST;
      wipe_coverage();
      coverage_reports.delete();
    end else begin
      // Check the result transfer against the oldest prediction first
      if (out_valid && !out_stall) begin
        if (coverage_reports.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, got uncovered=%0d status=%0d",
                   $time, out_data.uncovered_cells, out_data.status);
        end else begin
          want = coverage_reports.pop_front();
          if (out_data.uncovered_cells !== want.uncovered_cells) begin
            errors++;
            $display("%0t: uncovered_cells mismatch, expected %0d, actual %0d",
                     $time, want.uncovered_cells, out_data.uncovered_cells);
          end
          if (out_data.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_data.status);
          end
        end
      end
      // Register write clears coverage
      if (cfg_we) begin
        line_cells = cfg_wdata;
        wipe_coverage();
      end
      // Predict the report for each accepted range
      if (in_valid && !in_stall) coverage_reports.push_back(cover_range(in_data));
    end
    fail_count <= errors;
    pending    <= coverage_reports.size();
  end

endmodule

/* tb/sv/tb_interval_coverage_tracker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_interval_coverage_tracker: stimulus and verdict for the coverage tracker
// Drives directed and random cell ranges over several line lengths, with
// random idle bursts on both channels, and leaves prediction and comparison
// to the icov_checker scoreboard beside the block.
// ----------------------------------------------------------------------------

module tb_interval_coverage_tracker;
  import icov_pkg::*;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  icov_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  icov_out_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  bit bursts_on   = 1'b1;
  int hold_left   = 0;
  int ranges_sent = 0;
  int lines_used  = 1;

  interval_coverage_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  icov_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver stalls in bursts of random length
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (bursts_on && $urandom_range(0, 7) == 0) begin
      hold_left <= $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one range and hold it until the transfer
  task automatic send_range(input logic [31:0] f, input logic [31:0] l);
    icov_in_t r;
    r.first_cell = f;
    r.last_cell  = l;
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_data  <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ranges_sent++;
  endtask

  // Hold off the sender until every predicted report has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write the line length once the block is idle
  task automatic set_line(input logic [31:0] n);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we    <= 1'b0;
    lines_used++;
  endtask

  // Pick a range: mostly short well-formed ones near both ends of the line
  task automatic random_range(input logic [31:0] tot);
    logic [31:0] win;
    logic [31:0] len;
    logic [31:0] f;
    logic [31:0] l;
    int          sel;
    sel = $urandom_range(0, 99);
    win = (tot < 32'd400) ? tot : 32'd400;
    if (sel < 4 || tot == 32'd0) begin
      f = $urandom();
      l = $urandom();
    end else if (sel < 7) begin
      f = 32'd0;
      l = $urandom();
    end else if (sel < 10) begin
      f = $urandom_range(32'hFFFF_FFFF, 2);
      l = f - $urandom_range(1, 32'hFFFF_FFFF) % f;
      if (l >= f) l = f - 1;
    end else if (sel < 13 && tot != 32'hFFFF_FFFF) begin
      f = $urandom_range(1, 8);
      l = tot + $urandom_range(1, 32'hFFFF_FFFF - tot);
    end else if (sel < 15) begin
      f = 32'd1;
      l = tot;
    end else begin
      if ($urandom_range(0, 19) == 0) len = $urandom_range(1, win);
      else len = $urandom_range(1, (win < 8) ? win : 8);
      f = $urandom_range(1, win - len + 1);
      if (tot > win && sel[0]) f = tot - win + f;
      l = f + len - 1;
    end
    send_range(f, l);
  endtask

  // One line length: optional table fill, random ranges, optional mid drain
  task automatic run_line(input logic [31:0] tot, input int items,
                          input bit fill, input bit pause_mid);
    int i;
    set_line(tot);
    if (fill) begin
      // Sixty-four isolated cells fill the table; the next stray one drops
      for (i = 0; i < MAX_INTERVALS_DEF; i++) send_range(2 * i + 1, 2 * i + 1);
      send_range(32'd131, 32'd131);
      send_range(32'd2, 32'd2);
      send_range(32'd133, 32'd133);
    end
    for (i = 0; i < items; i++) begin
      if (pause_mid && i == items / 2) drain();
      random_range(tot);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ranges on the reset line length
    send_range(32'd0, 32'd5);
    send_range(32'd0, 32'd0);
    send_range(32'd10, 32'd9);
    send_range(32'd1, 32'd1025);
    send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_range(32'd1, 32'd1);
    send_range(32'd3, 32'd3);
    send_range(32'd2, 32'd2);
    send_range(32'd1024, 32'd1024);
    send_range(32'd1023, 32'd1023);
    send_range(32'd500, 32'd520);
    send_range(32'd510, 32'd530);
    send_range(32'd1, 32'd1024);
    send_range(32'd1024, 32'd1024);

    run_line(32'd200, 150, 1'b1, 1'b0);
    run_line(32'd1, 40, 1'b0, 1'b0);
    run_line(32'hFFFF_FFFF, 200, 1'b0, 1'b1);
    run_line(32'd60, 150, 1'b0, 1'b0);
    run_line(32'd0, 12, 1'b0, 1'b0);
    run_line(32'd5000, 200, 1'b0, 1'b0);

    // Closing stretch at full rate
    bursts_on = 1'b0;
    run_line(32'd700, 150, 1'b0, 1'b0);

    drain();
    repeat (MAX_INTERVALS_DEF + 8) @(posedge clk);

    $display("Sent %0d ranges over %0d line lengths, zero, one and the widest among them.",
             ranges_sent, lines_used);
    $display("Merges, table overflow, malformed ranges and full coverage ran under stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
